[hw/rtl/wcc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wcc_pkg
// Shared types and constants for the window co-occurrence counter.
// ----------------------------------------------------------------------------
package wcc_pkg;

    // Field widths fixed by the request and result formats.
    localparam int WORD_W  = 8;
    localparam int COUNT_W = 32;

    typedef logic [WORD_W-1:0]  word_t;
    typedef logic [COUNT_W-1:0] count_t;

    // Request kinds.
    localparam logic KIND_WORD = 1'b0;
    localparam logic KIND_READ = 1'b1;

    // Sequencer states.
    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_UPDATE,
        ST_READ
    } wcc_state_t;

    // Window control from the sequencer.
    typedef struct packed {
        logic push;
        logic rotate;
    } win_ctrl_t;

endpackage

[hw/rtl/wcc_window.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wcc_window
// Word window as a shift line. A push shifts a new word in at the far end;
// a rotate moves every word one place toward the front and wraps the front
// word to the far end, so the front tap walks the whole window.
// ----------------------------------------------------------------------------
module wcc_window #(
    parameter int HALF_WINDOW = 8
) (
    input  logic              clk,
    input  logic              rst_n,
    input  wcc_pkg::win_ctrl_t ctrl,
    input  wcc_pkg::word_t    word_in,
    output wcc_pkg::word_t    ctx_word,
    output wcc_pkg::word_t    center_next,
    output logic              full_after_push
);

    localparam int WIN_LEN = 2 * HALF_WINDOW + 1;
    localparam int FILL_W  = $clog2(WIN_LEN + 1);

    wcc_pkg::word_t    win_reg  [WIN_LEN];
    wcc_pkg::word_t    win_next [WIN_LEN];
    logic [FILL_W-1:0] fill_reg;
    logic [FILL_W-1:0] fill_next;

    // Shift or rotate the window contents.
    always_comb
    begin
        for (int i = 0; i < WIN_LEN; i++)
        begin
            win_next[i] = win_reg[i];
        end
        if (ctrl.push || ctrl.rotate)
        begin
            for (int i = 0; i < WIN_LEN - 1; i++)
            begin
                win_next[i] = win_reg[i + 1];
            end
            win_next[WIN_LEN-1] = ctrl.push ? word_in : win_reg[0];
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < WIN_LEN; i++)
        begin
            win_reg[i] <= win_next[i];
        end
    end

    // Fill level stops once the window is full.
    always_comb
    begin
        fill_next = fill_reg;
        if (ctrl.push && (fill_reg != FILL_W'(WIN_LEN)))
        begin
            fill_next = fill_reg + FILL_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
        end
        else
        begin
            fill_reg <= fill_next;
        end
    end

    // The center after a push is the word one place past the current center.
    assign ctx_word        = win_reg[0];
    assign center_next     = win_reg[HALF_WINDOW + 1];
    assign full_after_push = (fill_reg >= FILL_W'(WIN_LEN - 1));

endmodule

[hw/rtl/wcc_count_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wcc_count_ram
// Count memory: one write port and one read port with registered read data.
// A read and a write to the same entry in one cycle return the old value.
// ----------------------------------------------------------------------------
module wcc_count_ram #(
    parameter int ADDR_W = 16,
    parameter int DATA_W = 32
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] store [2**ADDR_W];
    logic [DATA_W-1:0] rdata_reg;

    // Write and read in the same clocked block.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            store[waddr] <= wdata;
        end
        rdata_reg <= store[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[hw/rtl/wcc_engine.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wcc_engine
// Sequencer and read-modify-write datapath. Clears the count memory after
// reset, walks the window for each centered word issuing one count read per
// cycle, and writes back the saturated increment in the following cycle with
// forwarding from the previous write. Also serves read requests.
// ----------------------------------------------------------------------------
module wcc_engine #(
    parameter int HALF_WINDOW = 8,
    parameter int VOCAB       = 256,
    parameter int ADDR_W      = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    // Request channel
    input  logic                in_valid,
    output logic                in_ready,
    input  logic                kind,
    input  wcc_pkg::word_t      row_index,
    input  wcc_pkg::word_t      col_index,
    // Result channel
    output logic                out_valid,
    input  logic                out_ready,
    output wcc_pkg::count_t     pair_count,
    // Window
    output wcc_pkg::win_ctrl_t  win_ctrl,
    input  wcc_pkg::word_t      ctx_word,
    input  wcc_pkg::word_t      center_next,
    input  logic                full_after_push,
    // Count memory
    output logic [ADDR_W-1:0]   raddr,
    input  wcc_pkg::count_t     rdata,
    output logic                we,
    output logic [ADDR_W-1:0]   waddr,
    output wcc_pkg::count_t     wdata
);

    localparam int WIN_LEN = 2 * HALF_WINDOW + 1;
    localparam int OPS     = 2 * WIN_LEN;
    localparam int OP_W    = $clog2(OPS);
    localparam int IDX_W   = ADDR_W / 2;
    localparam int EXT_W   = (IDX_W > wcc_pkg::WORD_W) ? IDX_W : wcc_pkg::WORD_W;

    wcc_pkg::wcc_state_t state_reg, state_next;
    logic [OP_W-1:0]     op_reg, op_next;
    wcc_pkg::word_t      center_reg, center_val_next;
    wcc_pkg::word_t      rd_row_reg, rd_row_next;
    wcc_pkg::word_t      rd_col_reg, rd_col_next;
    logic [ADDR_W-1:0]   clr_addr_reg, clr_addr_next;
    logic                pend_valid_reg, pend_valid_next;
    logic                pend_write_reg, pend_write_next;
    logic                pend_zero_reg, pend_zero_next;
    logic [ADDR_W-1:0]   pend_addr_reg, pend_addr_next;
    logic                last_valid_reg, last_valid_next;
    logic [ADDR_W-1:0]   last_addr_reg, last_addr_next;
    wcc_pkg::count_t     last_data_reg, last_data_next;
    logic                out_valid_reg, out_valid_next;
    wcc_pkg::count_t     out_data_reg, out_data_next;

    logic                accept;
    logic                phase;
    wcc_pkg::word_t      row_w;
    wcc_pkg::word_t      col_w;
    logic [ADDR_W-1:0]   issue_addr;
    logic                issue_ok;
    logic                fwd_hit;
    wcc_pkg::count_t     cur_count;
    wcc_pkg::count_t     inc_count;

    // True when a word index lies inside the vocabulary.
    function automatic logic in_vocab(input wcc_pkg::word_t w);
        return (32'(w) < 32'(VOCAB));
    endfunction

    // Word index as a memory row or column index.
    function automatic logic [IDX_W-1:0] to_idx(input wcc_pkg::word_t w);
        logic [EXT_W-1:0] ext;
        ext = EXT_W'(w);
        return ext[IDX_W-1:0];
    endfunction

    assign accept = in_valid && in_ready;
    assign phase  = op_reg[0];

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            wcc_pkg::ST_CLEAR:
            begin
                if (clr_addr_reg == '1)
                begin
                    state_next = wcc_pkg::ST_IDLE;
                end
            end
            wcc_pkg::ST_IDLE:
            begin
                if (accept && (kind == wcc_pkg::KIND_READ))
                begin
                    state_next = wcc_pkg::ST_READ;
                end
                else if (accept && full_after_push)
                begin
                    state_next = wcc_pkg::ST_UPDATE;
                end
            end
            wcc_pkg::ST_UPDATE:
            begin
                if (op_reg == OP_W'(OPS - 1))
                begin
                    state_next = wcc_pkg::ST_IDLE;
                end
            end
            wcc_pkg::ST_READ:
            begin
                state_next = wcc_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = wcc_pkg::ST_IDLE;
            end
        endcase
    end

    // Address of the count touched in this cycle.
    always_comb
    begin
        if (state_reg == wcc_pkg::ST_READ)
        begin
            row_w = rd_row_reg;
            col_w = rd_col_reg;
        end
        else
        begin
            row_w = phase ? ctx_word : center_reg;
            col_w = phase ? center_reg : ctx_word;
        end
        issue_addr = {to_idx(row_w), to_idx(col_w)};
        issue_ok   = in_vocab(row_w) && in_vocab(col_w);
    end

    // Read data with forwarding from the write of the previous cycle.
    always_comb
    begin
        fwd_hit   = last_valid_reg && (last_addr_reg == pend_addr_reg);
        cur_count = fwd_hit ? last_data_reg : rdata;
        inc_count = (cur_count == '1) ? cur_count : cur_count + wcc_pkg::count_t'(1);
    end

    // Sequencer outputs and datapath next values.
    always_comb
    begin
        // A read waits until no earlier result is held or still on its way.
        in_ready        = (state_reg == wcc_pkg::ST_IDLE)
                          && ((kind == wcc_pkg::KIND_WORD)
                              || (!out_valid_reg && !(pend_valid_reg && !pend_write_reg)));
        win_ctrl.push   = accept && (kind == wcc_pkg::KIND_WORD);
        win_ctrl.rotate = (state_reg == wcc_pkg::ST_UPDATE) && phase;

        op_next         = '0;
        center_val_next = center_reg;
        rd_row_next     = rd_row_reg;
        rd_col_next     = rd_col_reg;
        clr_addr_next   = clr_addr_reg;
        pend_valid_next = 1'b0;
        pend_write_next = 1'b0;
        pend_zero_next  = !issue_ok;
        pend_addr_next  = issue_addr;

        unique case (state_reg)
            wcc_pkg::ST_CLEAR:
            begin
                clr_addr_next = clr_addr_reg + ADDR_W'(1);
            end
            wcc_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    center_val_next = center_next;
                    rd_row_next     = row_index;
                    rd_col_next     = col_index;
                end
            end
            wcc_pkg::ST_UPDATE:
            begin
                op_next         = op_reg + OP_W'(1);
                pend_valid_next = issue_ok;
                pend_write_next = 1'b1;
            end
            wcc_pkg::ST_READ:
            begin
                pend_valid_next = 1'b1;
            end
            default:
            begin
                op_next = '0;
            end
        endcase

        raddr = issue_addr;

        // Memory write: clearing pass, or write-back of an increment.
        if (state_reg == wcc_pkg::ST_CLEAR)
        begin
            we    = 1'b1;
            waddr = clr_addr_reg;
            wdata = '0;
        end
        else
        begin
            we    = pend_valid_reg && pend_write_reg;
            waddr = pend_addr_reg;
            wdata = inc_count;
        end

        last_valid_next = pend_valid_reg && pend_write_reg;
        last_addr_next  = pend_addr_reg;
        last_data_next  = inc_count;

        // Result register.
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (pend_valid_reg && !pend_write_reg)
        begin
            out_valid_next = 1'b1;
            out_data_next  = pend_zero_reg ? '0 : cur_count;
        end
        else if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= wcc_pkg::ST_CLEAR;
            op_reg         <= '0;
            clr_addr_reg   <= '0;
            pend_valid_reg <= 1'b0;
            last_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            op_reg         <= op_next;
            clr_addr_reg   <= clr_addr_next;
            pend_valid_reg <= pend_valid_next;
            last_valid_reg <= last_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        center_reg     <= center_val_next;
        rd_row_reg     <= rd_row_next;
        rd_col_reg     <= rd_col_next;
        pend_write_reg <= pend_write_next;
        pend_zero_reg  <= pend_zero_next;
        pend_addr_reg  <= pend_addr_next;
        last_addr_reg  <= last_addr_next;
        last_data_reg  <= last_data_next;
        out_data_reg   <= out_data_next;
    end

    assign out_valid  = out_valid_reg;
    assign pair_count = out_data_reg;

endmodule

[hw/rtl/window_cooccurrence_counter.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// window_cooccurrence_counter
// Counts how often two words appear within HALF_WINDOW places of each other.
// After reset the count memory is cleared one entry per cycle, all
// 2**(2*ceil(log2(VOCAB))) entries (65536 at the defaults); no request is
// accepted during that pass. While the window is still filling, a word
// request only shifts the word in; once it is full, each word request starts
// a walk over the window, during which no request is accepted: every window
// position costs two count updates, and the count memory, with one read and
// one write port, does one read-modify-write per cycle. A read goes through
// the read state, the pending stage and the result register, and is accepted
// only while the result register is empty and no earlier read is pending.
// Counts saturate at 32 bits; out-of-vocabulary words never change a count.
// ----------------------------------------------------------------------------
module window_cooccurrence_counter #(
    parameter int HALF_WINDOW = 8,
    parameter int VOCAB       = 256
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  logic            kind,
    input  wcc_pkg::word_t  word_index,
    input  wcc_pkg::word_t  row_index,
    input  wcc_pkg::word_t  col_index,
    output logic            out_valid,
    input  logic            out_ready,
    output wcc_pkg::count_t pair_count
);

    localparam int IDX_W  = $clog2(VOCAB);
    localparam int ADDR_W = 2 * IDX_W;

    wcc_pkg::win_ctrl_t win_ctrl;
    wcc_pkg::word_t     ctx_word;
    wcc_pkg::word_t     center_next;
    logic               full_after_push;
    logic [ADDR_W-1:0]  raddr;
    logic [ADDR_W-1:0]  waddr;
    logic               we;
    wcc_pkg::count_t    rdata;
    wcc_pkg::count_t    wdata;

    // Word window.
    wcc_window #(
        .HALF_WINDOW (HALF_WINDOW)
    ) u_window (
        .clk             (clk),
        .rst_n           (rst_n),
        .ctrl            (win_ctrl),
        .word_in         (word_index),
        .ctx_word        (ctx_word),
        .center_next     (center_next),
        .full_after_push (full_after_push)
    );

    // Sequencer and update datapath.
    wcc_engine #(
        .HALF_WINDOW (HALF_WINDOW),
        .VOCAB       (VOCAB),
        .ADDR_W      (ADDR_W)
    ) u_engine (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .kind            (kind),
        .row_index       (row_index),
        .col_index       (col_index),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .pair_count      (pair_count),
        .win_ctrl        (win_ctrl),
        .ctx_word        (ctx_word),
        .center_next     (center_next),
        .full_after_push (full_after_push),
        .raddr           (raddr),
        .rdata           (rdata),
        .we              (we),
        .waddr           (waddr),
        .wdata           (wdata)
    );

    // Count memory.
    wcc_count_ram #(
        .ADDR_W (ADDR_W),
        .DATA_W (wcc_pkg::COUNT_W)
    ) u_count_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    // A read request is only taken while the result register is empty.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && (kind == wcc_pkg::KIND_READ)) |-> !out_valid)
        else $error("read request accepted while a result is pending");

    // Every read request shows its result after the read state, pending stage and result register.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && (kind == wcc_pkg::KIND_READ)) |-> ##3 out_valid)
        else $error("read result did not appear three cycles after request");

    // A result only appears because of a read request.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && in_ready && (kind == wcc_pkg::KIND_READ), 3))
        else $error("result appeared without a matching read request");

endmodule

[tb/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the sliding-window co-occurrence counter. Requests
// come from a queue that the stimulus process fills. A running model of the
// window and the count store predicts every read, and each returned count is
// checked in order against it. Both sides of the handshake stall at random.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int HALF_WINDOW = 8;
    localparam int VOCAB       = 256;
    localparam int WIN_LEN     = 2 * HALF_WINDOW + 1;
    localparam int WORD_BUSY   = 2 * WIN_LEN + 1;
    localparam int RANDOM_REQS = 425;

    // One request as it waits to be driven.
    typedef struct packed {
        logic           kind;
        wcc_pkg::word_t word;
        wcc_pkg::word_t row;
        wcc_pkg::word_t col;
    } wcc_req_t;

    logic            clk        = 1'b0;
    logic            rst_n      = 1'b0;
    logic            in_valid   = 1'b0;
    logic            kind       = wcc_pkg::KIND_WORD;
    wcc_pkg::word_t  word_index = '0;
    wcc_pkg::word_t  row_index  = '0;
    wcc_pkg::word_t  col_index  = '0;
    logic            out_ready  = 1'b0;
    logic            in_ready;
    logic            out_valid;
    wcc_pkg::count_t pair_count;

    wcc_req_t        pending_reqs[$];
    wcc_pkg::count_t expected_counts[$];
    int              accepted_reqs  = 0;
    int              mismatch_count = 0;

    // Running model of the block: the word window and the count store.
    bit [wcc_pkg::WORD_W-1:0]  win_words [WIN_LEN];
    int                        win_fill = 0;
    bit [wcc_pkg::COUNT_W-1:0] cnt_store [VOCAB * VOCAB];

    window_cooccurrence_counter #(
        .HALF_WINDOW (HALF_WINDOW),
        .VOCAB       (VOCAB)
    ) u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .kind       (kind),
        .word_index (word_index),
        .row_index  (row_index),
        .col_index  (col_index),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .pair_count (pair_count)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Saturating increment of one count; pairs outside the vocabulary are dropped.
    function automatic void bump_pair(int row, int col);
        int at;
        if (row >= VOCAB || col >= VOCAB)
            return;
        at = row * VOCAB + col;
        if (cnt_store[at] != '1)
            cnt_store[at] = cnt_store[at] + 32'd1;
    endfunction

    // Shift a word into the window and, once it is full, count the center's pairs.
    function automatic void shift_in_word(wcc_pkg::word_t w);
        int center;
        if (win_fill < WIN_LEN)
        begin
            win_words[win_fill] = w;
            win_fill++;
        end
        else
        begin
            for (int k = 0; k < WIN_LEN - 1; k++)
                win_words[k] = win_words[k + 1];
            win_words[WIN_LEN - 1] = w;
        end
        if (win_fill < WIN_LEN)
            return;
        center = win_words[HALF_WINDOW];
        for (int k = 0; k < WIN_LEN; k++)
        begin
            bump_pair(center, win_words[k]);
            bump_pair(win_words[k], center);
        end
    endfunction

    function automatic wcc_pkg::count_t lookup_count(wcc_pkg::word_t row,
                                                     wcc_pkg::word_t col);
        if (row >= VOCAB || col >= VOCAB)
            return '0;
        return cnt_store[int'(row) * VOCAB + int'(col)];
    endfunction

    // A long stretch in the middle of the run goes without any stalls.
    function automatic logic take_break();
        if (accepted_reqs >= 150 && accepted_reqs < 300)
            return 1'b0;
        return $urandom_range(99) < 14;
    endfunction

    // Word request; the read indices carry random noise.
    task automatic queue_word(wcc_pkg::word_t w);
        wcc_req_t req;
        req.kind = wcc_pkg::KIND_WORD;
        req.word = w;
        req.row  = wcc_pkg::word_t'($urandom_range(255));
        req.col  = wcc_pkg::word_t'($urandom_range(255));
        pending_reqs = {pending_reqs, req};
    endtask

    // Read request; the word field carries random noise.
    task automatic queue_read(wcc_pkg::word_t row, wcc_pkg::word_t col);
        wcc_req_t req;
        req.kind = wcc_pkg::KIND_READ;
        req.word = wcc_pkg::word_t'($urandom_range(255));
        req.row  = row;
        req.col  = col;
        pending_reqs = {pending_reqs, req};
    endtask

    // Wait until every queued request is accepted and every count has returned.
    task automatic wait_drained();
        do
            @(negedge clk);
        while (pending_reqs.size() != 0 || in_valid || expected_counts.size() != 0);
    endtask

    // Request driver: updates the model on each accepted request, then presents the next.
    always @(posedge clk or negedge rst_n)
    begin : drive_requests
        wcc_req_t next_req;
        if (!rst_n)
        begin
            in_valid   <= 1'b0;
            kind       <= wcc_pkg::KIND_WORD;
            word_index <= '0;
            row_index  <= '0;
            col_index  <= '0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                accepted_reqs <= accepted_reqs + 1;
                if (kind == wcc_pkg::KIND_WORD)
                    shift_in_word(word_index);
                else
                    expected_counts = {expected_counts, lookup_count(row_index, col_index)};
            end
            if (!in_valid || in_ready)
            begin
                if (pending_reqs.size() != 0 && !take_break())
                begin
                    next_req = pending_reqs.pop_front();
                    kind       <= next_req.kind;
                    word_index <= next_req.word;
                    row_index  <= next_req.row;
                    col_index  <= next_req.col;
                    in_valid   <= 1'b1;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor: every returned count must match the oldest prediction.
    always @(posedge clk or negedge rst_n)
    begin : check_results
        wcc_pkg::count_t want;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_counts.size() == 0)
                begin
                    $display("%0t ns: unexpected result, expected none, actual pair_count %0d",
                             $time, pair_count);
                    mismatch_count++;
                end
                else
                begin
                    want = expected_counts.pop_front();
                    if (pair_count !== want)
                    begin
                        $display("%0t ns: pair_count mismatch, expected %0d, actual %0d",
                                 $time, want, pair_count);
                        mismatch_count++;
                    end
                end
            end
            out_ready <= !take_break();
        end
    end

    // Hard limit on the run: clearing pass plus every request at its slowest.
    initial
    begin
        #5ms;
        $display("FAIL");
        $finish;
    end

    // Stimulus and end of test.
    initial
    begin : stimulus
        wcc_pkg::word_t recent[$];
        wcc_pkg::word_t w;
        wcc_pkg::word_t r;
        wcc_pkg::word_t c;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // Reads of an empty store, at both ends of the index range.
        queue_read(8'd0, 8'd0);
        queue_read(8'd255, 8'd255);
        // Fill the window with alternating extremes; no count moves until it is full.
        for (int k = 0; k < WIN_LEN - 1; k++)
            queue_word((k % 2 == 0) ? 8'd255 : 8'd0);
        queue_read(8'd255, 8'd255);
        // The word that fills the window makes the first center.
        queue_word(8'd255);
        queue_read(8'd255, 8'd255);
        queue_read(8'd255, 8'd0);
        queue_read(8'd0, 8'd255);
        // Next word shifts the window; center is now a zero.
        queue_word(8'h5A);
        queue_read(8'd0, 8'd0);
        wait_drained();

        for (int i = 0; i < RANDOM_REQS; i++)
        begin
            // Hold off once mid-run until every outstanding count has returned.
            if (i == RANDOM_REQS / 2)
                wait_drained();
            if (recent.size() == 0 || $urandom_range(99) < 65)
            begin
                // Mostly a small hot alphabet so pairs repeat, with some spread.
                if ($urandom_range(99) < 75)
                begin
                    w = wcc_pkg::word_t'($urandom_range(11));
                    if (w >= 8)
                        w = w + 8'd244;
                end
                else
                begin
                    w = wcc_pkg::word_t'($urandom_range(255));
                end
                queue_word(w);
                recent = {recent, w};
                if (recent.size() > 24)
                    void'(recent.pop_front());
            end
            else
            begin
                r = ($urandom_range(99) < 80) ? recent[$urandom_range(recent.size() - 1)]
                                              : wcc_pkg::word_t'($urandom_range(255));
                c = ($urandom_range(99) < 80) ? recent[$urandom_range(recent.size() - 1)]
                                              : wcc_pkg::word_t'($urandom_range(255));
                queue_read(r, c);
            end
        end

        wait_drained();
        repeat (WORD_BUSY + 10) @(posedge clk);
        if (mismatch_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
